/* sv/gscb_pkg.sv */
package gscb_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_CINIT,
    ST_CDIV,
    ST_CBND,
    ST_IDLE,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_QINIT,
    ST_QDIV,
    ST_OUT
  } state_t;

  // Configuration register indexes
  localparam logic [1:0] REG_BAND_START  = 2'd0;
  localparam logic [1:0] REG_BAND_ROWS   = 2'd1;
  localparam logic [1:0] REG_SLICE_INDEX = 2'd2;
  localparam logic [1:0] REG_SLICE_COUNT = 2'd3;

  // Quotient bits of the final divide and the step counter width
  localparam int Q_BITS = 16;
  localparam int STEP_W = 5;

  localparam logic [15:0] NEUTRAL_VALUE = 16'd16384;
  localparam logic [15:0] FULL_VALUE    = 16'd32768;
  // 4800 = 20 (weight scale) * 240 (common denominator of the bias terms)
  localparam logic [12:0] DEN_SCALE     = 13'd4800;

  // Commands from controller to datapath
  typedef struct packed {
    logic cfg_we;
    logic cdiv_init;
    logic cdiv_step;
    logic bnd_load;
    logic acc_en;
    logic fin1;
    logic fin2;
    logic fin3;
    logic fin4;
    logic q_init;
    logic q_step;
    logic out_load;
  } cmd_t;

  // Status from datapath and ports to controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic cfg_valid;
    logic out_full;
    logic out_taken;
  } stat_t;

  // Colour weight, scaled by 20
  function automatic logic signed [5:0] colour_weight(input logic [3:0] colour);
    logic signed [5:0] w;
    unique case (colour)
      4'd1:    w = -6'sd16;
      4'd2:    w = 6'sd11;
      4'd3:    w = 6'sd16;
      4'd4:    w = -6'sd14;
      4'd5:    w = -6'sd20;
      4'd6:    w = 6'sd14;
      4'd7:    w = 6'sd18;
      4'd8:    w = -6'sd11;
      4'd10:   w = -6'sd12;
      4'd11:   w = -6'sd18;
      4'd12:   w = 6'sd12;
      default: w = 6'sd0;
    endcase
    return w;
  endfunction

endpackage

/* sv/gscb_ctrl.sv */
module gscb_ctrl #(
  parameter int GRID_DIM = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gscb_pkg::stat_t st,
  output logic            in_ready,
  output logic            cfg_ready,
  output gscb_pkg::cmd_t  cmd
);

  localparam int SPAN_W = $clog2(16 * GRID_DIM + 1);

  gscb_pkg::state_t state_r, state_nxt;
  logic [gscb_pkg::STEP_W-1:0] step_r, step_nxt;
  logic in_acc, cfg_acc;

  assign in_acc  = st.in_valid && in_ready;
  assign cfg_acc = st.cfg_valid && cfg_ready;

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gscb_pkg::ST_CINIT;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    if (state_r == gscb_pkg::ST_CDIV || state_r == gscb_pkg::ST_QDIV) begin
      step_nxt = step_r + 1'b1;
    end else begin
      step_nxt = '0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gscb_pkg::ST_CINIT: state_nxt = gscb_pkg::ST_CDIV;
      gscb_pkg::ST_CDIV: begin
        if (step_r == gscb_pkg::STEP_W'(SPAN_W - 1)) state_nxt = gscb_pkg::ST_CBND;
      end
      gscb_pkg::ST_CBND: state_nxt = gscb_pkg::ST_IDLE;
      gscb_pkg::ST_IDLE: begin
        priority if (cfg_acc) state_nxt = gscb_pkg::ST_CINIT;
        else if (in_acc && st.in_last) state_nxt = gscb_pkg::ST_FIN1;
        else state_nxt = gscb_pkg::ST_IDLE;
      end
      gscb_pkg::ST_FIN1:  state_nxt = gscb_pkg::ST_FIN2;
      gscb_pkg::ST_FIN2:  state_nxt = gscb_pkg::ST_FIN3;
      gscb_pkg::ST_FIN3:  state_nxt = gscb_pkg::ST_FIN4;
      gscb_pkg::ST_FIN4:  state_nxt = gscb_pkg::ST_QINIT;
      gscb_pkg::ST_QINIT: state_nxt = gscb_pkg::ST_QDIV;
      gscb_pkg::ST_QDIV: begin
        if (step_r == gscb_pkg::STEP_W'(gscb_pkg::Q_BITS - 1)) state_nxt = gscb_pkg::ST_OUT;
      end
      gscb_pkg::ST_OUT: begin
        if (!st.out_full || st.out_taken) state_nxt = gscb_pkg::ST_IDLE;
      end
      default: state_nxt = gscb_pkg::ST_CINIT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = (state_r == gscb_pkg::ST_IDLE);
    // a request on the input wins over a config write in the same cycle
    cfg_ready = (state_r == gscb_pkg::ST_IDLE) && !st.in_valid;
    cmd           = '0;
    cmd.cfg_we    = cfg_acc;
    cmd.acc_en    = in_acc;
    cmd.cdiv_init = (state_r == gscb_pkg::ST_CINIT);
    cmd.cdiv_step = (state_r == gscb_pkg::ST_CDIV);
    cmd.bnd_load  = (state_r == gscb_pkg::ST_CBND);
    cmd.fin1      = (state_r == gscb_pkg::ST_FIN1);
    cmd.fin2      = (state_r == gscb_pkg::ST_FIN2);
    cmd.fin3      = (state_r == gscb_pkg::ST_FIN3);
    cmd.fin4      = (state_r == gscb_pkg::ST_FIN4);
    cmd.q_init    = (state_r == gscb_pkg::ST_QINIT);
    cmd.q_step    = (state_r == gscb_pkg::ST_QDIV);
    cmd.out_load  = (state_r == gscb_pkg::ST_OUT) && (!st.out_full || st.out_taken);
  end

`ifndef SYNTHESIS
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && cfg_acc))
    else $error("input and config requests taken together");
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && st.in_last) |=> !in_ready)
    else $error("input taken during result computation");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!st.out_full || st.out_taken))
    else $error("result overwrites pending output");
`endif

endmodule

/* sv/gscb_dp.sv */
module gscb_dp #(
  parameter int GRID_DIM = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gscb_pkg::cmd_t  cmd,
  output gscb_pkg::stat_t st,
  input  logic            in_valid,
  input  logic [3:0]      cell_colour,
  input  logic            last_cell,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [4:0]      cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     param_value
);

  localparam int TOTAL  = GRID_DIM * GRID_DIM;
  localparam int POS_W  = $clog2(TOTAL + 1);
  localparam int CNT_W  = POS_W;
  localparam int SPAN_W = $clog2(16 * GRID_DIM + 1);
  localparam int CW     = POS_W + SPAN_W;
  localparam int WS_W   = $clog2(20 * TOTAL + 1) + 1;
  localparam int AS_W   = WS_W - 1;
  localparam int TP_W   = 2 * CNT_W;
  localparam int D_W    = TP_W + 13;
  localparam int UP_W   = CNT_W + 4;
  localparam int N_W    = $clog2(240 * TOTAL + 1);
  localparam int SN_W   = WS_W + N_W + 1;
  localparam int X_W    = ((D_W + 14 > SN_W + 15) ? D_W + 14 : SN_W + 15) + 2;
  localparam int R_W    = D_W + 16;

  // Configuration registers
  logic [3:0] band_start_r, slice_index_r;
  logic [4:0] band_rows_r, slice_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_start_r  <= 4'd0;
      band_rows_r   <= 5'd16;
      slice_index_r <= 4'd0;
      slice_count_r <= 5'd1;
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        gscb_pkg::REG_BAND_START:  band_start_r  <= cfg_data[3:0];
        gscb_pkg::REG_BAND_ROWS:   band_rows_r   <= cfg_data;
        gscb_pkg::REG_SLICE_INDEX: slice_index_r <= cfg_data[3:0];
        gscb_pkg::REG_SLICE_COUNT: slice_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slice width: span / slice_count, one quotient bit a cycle
  logic [SPAN_W-1:0] span, cq_r;
  logic [4:0]        cr_r;
  logic [5:0]        ctrial;

  assign span   = SPAN_W'(GRID_DIM) * SPAN_W'(band_rows_r);
  assign ctrial = {cr_r, cq_r[SPAN_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.cdiv_init) begin
      cq_r <= span;
      cr_r <= '0;
    end else if (cmd.cdiv_step) begin
      if (ctrial >= {1'b0, slice_count_r}) begin
        cr_r <= 5'(ctrial - {1'b0, slice_count_r});
        cq_r <= {cq_r[SPAN_W-2:0], 1'b1};
      end else begin
        cr_r <= ctrial[4:0];
        cq_r <= {cq_r[SPAN_W-2:0], 1'b0};
      end
    end
  end

  // Slice bounds in raster positions
  logic [CW-1:0] base_r, lo_r, hi_r, lo_c;
  logic          keep_en_r;

  assign lo_c = CW'(slice_index_r) * CW'(cq_r);

  always_ff @(posedge clk) begin
    if (cmd.bnd_load) begin
      base_r    <= CW'(band_start_r) * CW'(GRID_DIM);
      lo_r      <= lo_c;
      hi_r      <= ({1'b0, slice_index_r} + 5'd1 == slice_count_r) ? CW'(span)
                                                                   : lo_c + CW'(cq_r);
      keep_en_r <= (band_rows_r != 5'd0) && (slice_count_r != 5'd0);
    end
  end

  // Per-cell accumulation
  logic [POS_W-1:0]       pos_r;
  logic signed [WS_W-1:0] ws_r;
  logic [AS_W-1:0]        as_r;
  logic [CNT_W-1:0]       pc_r, tc_r;
  logic [11:0]            mask_r;
  logic [CW-1:0]          local_pos;
  logic                   kept;
  logic signed [5:0]      w;
  logic [4:0]             wabs;

  assign local_pos = CW'(pos_r) - base_r;
  assign kept = keep_en_r && (pos_r < POS_W'(TOTAL)) && (CW'(pos_r) >= base_r)
                && (local_pos >= lo_r) && (local_pos < hi_r);
  assign w    = gscb_pkg::colour_weight(cell_colour);
  assign wabs = w[5] ? 5'(-w) : w[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      pos_r  <= '0;
      ws_r   <= '0;
      as_r   <= '0;
      pc_r   <= '0;
      tc_r   <= '0;
      mask_r <= '0;
    end else if (cmd.acc_en) begin
      if (pos_r < POS_W'(TOTAL)) pos_r <= pos_r + 1'b1;
      if (kept) begin
        tc_r <= tc_r + 1'b1;
        if (cell_colour != 4'd0) begin
          pc_r <= pc_r + 1'b1;
          ws_r <= ws_r + {{(WS_W-6){w[5]}}, w};
          as_r <= as_r + AS_W'(wabs);
          if (cell_colour <= 4'd12) mask_r[cell_colour - 4'd1] <= 1'b1;
        end
      end
    end
  end

  // Distinct colour count
  logic [3:0] ucnt;
  always_comb begin
    ucnt = '0;
    for (int i = 0; i < 12; i++) ucnt = ucnt + 4'(mask_r[i]);
  end

  // Final value pipeline: products, numerator/denominator, then divide
  logic [TP_W-1:0]        tp_r;
  logic [UP_W-1:0]        up_r;
  logic                   neutral_r, neg_r, big_r;
  logic [D_W-1:0]         d_r;
  logic [N_W-1:0]         n_r;
  logic signed [SN_W-1:0] sn_r;
  logic signed [X_W-1:0]  x_r;
  logic [R_W-1:0]         rem_r, dsh_r;
  logic [15:0]            q_r;

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      tp_r      <= TP_W'(tc_r) * TP_W'(pc_r);
      up_r      <= UP_W'(ucnt) * UP_W'(pc_r);
      neutral_r <= (band_rows_r == 5'd0) || (slice_count_r == 5'd0)
                   || (tc_r == '0) || (pc_r == '0);
    end
    if (cmd.fin2) begin
      d_r <= D_W'(tp_r) * D_W'(gscb_pkg::DEN_SCALE);
      n_r <= N_W'(pc_r) * N_W'(60) + N_W'(up_r) * N_W'(10) + N_W'(as_r) * N_W'(3);
    end
    if (cmd.fin3) begin
      sn_r <= {{(SN_W-WS_W){ws_r[WS_W-1]}}, ws_r} * $signed({{(SN_W-N_W){1'b0}}, n_r});
    end
    if (cmd.fin4) begin
      x_r <= $signed({{(X_W-D_W-14){1'b0}}, d_r, 14'b0})
           + $signed({{(X_W-SN_W-15){sn_r[SN_W-1]}}, sn_r, 15'b0});
    end
    if (cmd.q_init) begin
      neg_r <= x_r[X_W-1] || (x_r == '0);
      big_r <= x_r >= $signed({{(X_W-D_W-16){1'b0}}, d_r, 16'b0});
      rem_r <= x_r[R_W-1:0];
      dsh_r <= {1'b0, d_r, 15'b0};
      q_r   <= '0;
    end else if (cmd.q_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        q_r   <= {q_r[14:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // Output register
  logic        out_valid_r;
  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      priority if (neutral_r) out_data_r <= gscb_pkg::NEUTRAL_VALUE;
      else if (neg_r) out_data_r <= '0;
      else if (big_r || q_r > gscb_pkg::FULL_VALUE) out_data_r <= gscb_pkg::FULL_VALUE;
      else out_data_r <= q_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign param_value  = out_data_r;
  assign st.in_valid  = in_valid;
  assign st.in_last   = last_cell;
  assign st.cfg_valid = cfg_valid;
  assign st.out_full  = out_valid_r;
  assign st.out_taken = out_ready;

endmodule

/* sv/grid_slice_colour_bias_top.sv */
// Grid slice colour bias: takes a GRID_DIM x GRID_DIM painted grid in raster
// order, one cell per request, keeps the cells of the configured row band and
// slice, and on the request marked tlast delivers one Q1.15 parameter value
// 0.5 + (S/T)*(0.25 + U/24 + A/(4P)), clamped to 0..1 (16384 when nothing is
// painted, the slice is empty, or band_rows or slice_count is zero). Cells
// are taken one per cycle while in_tready is high. After the last cell the
// block computes with in_tready low (product stages, then a restoring
// divider) and then holds the result in the output register, taking new
// cells meanwhile. If the previous result is still waiting in the output
// register when the next one is ready, in_tready stays low until that
// earlier result is taken. A config write, and reset, recompute the slice
// width with a bit-serial divider and keep in_tready low meanwhile.
module grid_slice_colour_bias_top #(
  parameter int GRID_DIM = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] cell_colour, [7:4] zero
  input  logic        in_tlast,   // last_cell
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] param_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  gscb_pkg::cmd_t  cmd;
  gscb_pkg::stat_t st;

  gscb_ctrl #(.GRID_DIM(GRID_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .st        (st),
    .in_ready  (in_tready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  gscb_dp #(.GRID_DIM(GRID_DIM)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_valid    (in_tvalid),
    .cell_colour (in_tdata[3:0]),
    .last_cell   (in_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .param_value (out_tdata)
  );

endmodule
